@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsir assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsir assertion failed");

`endif

@@ rtl/wsir_pkg.sv @@
// ---------------------------------------------------------------------------
// wsir_pkg
// shared constants, types and helpers of the weight stream inverse reorder
// ---------------------------------------------------------------------------
package wsir_pkg;

    localparam int IN_UBLOCK    = 8;
    localparam int OUT_UBLOCK   = 8;
    localparam int ADDR_WIDTH   = 20;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_KERNEL   = 64;

    localparam int CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int K_W  = $clog2(MAX_KERNEL + 1);
    localparam int IM_W = $clog2(IN_UBLOCK + 1);
    localparam int OM_W = $clog2(OUT_UBLOCK + 1);
    localparam int SE_W = 2 * K_W + 1;
    localparam int CI_W = 6;
    localparam int IB_W = CI_W + IM_W + 1;
    localparam int OU_W = 9 + OM_W;
    localparam int A1_W = CH_W + K_W + 2;
    localparam int A2_W = A1_W + K_W + 1;
    localparam int A3_W = A2_W + CH_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // configuration word widths
    localparam int OC_REG_W  = 11;
    localparam int KS_REG_W  = 7;
    localparam int OBD_REG_W = 8;
    localparam int MD_REG_W  = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_OUT_CHANNELS    = 3'd0,
        REG_IN_CHANNELS     = 3'd1,
        REG_KERNEL_HEIGHT   = 3'd2,
        REG_KERNEL_WIDTH    = 3'd3,
        REG_OUT_BLOCK_DEPTH = 3'd4,
        REG_DECOMP_HEIGHT   = 3'd5,
        REG_DECOMP_WIDTH    = 3'd6,
        REG_MODE            = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0]  ofm_d;
        logic [CH_W-1:0]  ifm_d;
        logic [CH_W-1:0]  in_bound;
        logic [K_W-1:0]   kh;
        logic [K_W-1:0]   kw;
        logic [K_W-1:0]   dh;
        logic [K_W-1:0]   dwd;
        logic [OBD_REG_W-1:0] obd;
        logic [CI_W-1:0]  ibd;
        logic             dw;
        logic             pk;
        logic             b16;
        logic             empty;
    } t_geom;

    typedef struct packed {
        logic              we_ok;
        logic [CH_W:0]     oz;
        logic [K_W:0]      y;
        logic [K_W:0]      x;
        logic [CH_W:0]     iz;
        logic signed [15:0] weight;
        logic              done_res;
        logic              short_stream;
    } t_entry;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROW,
        BK_COL,
        BK_CHAN
    } t_back_state;

    function automatic logic [CH_W-1:0] sat_ch(input logic [OC_REG_W-1:0] v);
        if (32'(v) > MAX_CHANNELS) begin
            return CH_W'(MAX_CHANNELS);
        end
        return CH_W'(v);
    endfunction

    function automatic logic [K_W-1:0] sat_k(input logic [KS_REG_W-1:0] v);
        if (32'(v) > MAX_KERNEL) begin
            return K_W'(MAX_KERNEL);
        end
        return K_W'(v);
    endfunction

endpackage

@@ rtl/wsir_if.sv @@
// ---------------------------------------------------------------------------
// wsir interfaces
// weight input channel and address result channel
// ---------------------------------------------------------------------------
interface wsir_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] weight;
    logic               last;

    modport source (output valid, output weight, output last, input ready);
    modport sink (input valid, input weight, input last, output ready);
endinterface

interface wsir_res_if;
    import wsir_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  write_enable;
    logic [ADDR_WIDTH-1:0] address;
    logic signed [15:0]    value;
    logic                  done_res;
    logic                  short_stream;

    modport source (output valid, output write_enable, output address, output value,
                    output done_res, output short_stream, input ready);
    modport sink (input valid, input write_enable, input address, input value,
                  input done_res, input short_stream, output ready);
endinterface

@@ rtl/wsir_fifo.sv @@
// ---------------------------------------------------------------------------
// wsir_fifo
// short queue of classified transactions between front and back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsir_fifo
    import wsir_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + CNT_W'(1))
    `ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - CNT_W'(1))

endmodule

@@ rtl/wsir_front.sv @@
// ---------------------------------------------------------------------------
// wsir_front
// traversal counters: classifies each weight and queues its coordinates
// ---------------------------------------------------------------------------
module wsir_front
    import wsir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_geom       i_geom,
    input  logic        i_restart,
    wsir_in_if.sink     i_in,
    output logic        o_push,
    output t_entry      o_entry,
    input  logic        i_full
);

    logic [IM_W-1:0] r_im, n_im;
    logic [OM_W-1:0] r_om, n_om;
    logic [IB_W-1:0] r_iin, n_iin;
    logic [SE_W-1:0] r_el, n_el;
    logic [K_W:0]    r_kx, n_kx;
    logic [K_W:0]    r_ky, n_ky;
    logic [OU_W-1:0] r_ouo, n_ouo;
    logic [IB_W-1:0] r_ioo, n_ioo;
    logic [K_W-1:0]  r_skc, n_skc;
    logic [K_W-1:0]  r_skr, n_skr;
    logic [CH_W-1:0] r_ibb, n_ibb;
    logic [CH_W-1:0] r_obb, n_obb;
    logic            r_finished, n_finished;

    logic              accept;
    logic              active;
    logic [K_W-1:0]    sub_h, sub_w, rem_h, rem_w;
    logic [2*K_W-1:0]  se_raw;
    logic [SE_W-1:0]   se, se_r1, se_r3;
    logic [CH_W-1:0]   rem_o, rem_i;
    logic [7:0]        out_blk_lim;
    logic [CI_W-1:0]   in_blk_lim, outer_lim, inner_lim;
    logic [IM_W-1:0]   im_bound;
    logic [IM_W:0]     s_im;
    logic [OM_W:0]     s_om;
    logic [IB_W-1:0]   s_iin, s_ioo;
    logic [SE_W-1:0]   s_el;
    logic [K_W:0]      s_kx;
    logic [OU_W-1:0]   s_ouo;
    logic [K_W:0]      s_skc, s_skr;
    logic [CH_W+7:0]   s_ibb, s_obb;
    logic              w_im, w_om, w_iin, w_el, w_ouo, w_ioo, w_skc, w_skr, w_ibb, w_obb;
    logic              e1, e2, e3, e4, e5, e6, e7, e8, e9, done;
    logic [CH_W:0]     iz, oz;

    assign accept   = i_in.valid && !i_full;
    assign i_in.ready = !i_full;
    assign o_push   = accept;

    always_comb begin
        active = !r_finished && !i_geom.empty && (r_obb < i_geom.ofm_d)
            && (r_ibb < i_geom.in_bound) && (r_skr < i_geom.kh) && (r_skc < i_geom.kw);

        rem_h  = i_geom.kh - r_skr;
        rem_w  = i_geom.kw - r_skc;
        sub_h  = (rem_h < i_geom.dh) ? rem_h : i_geom.dh;
        sub_w  = (rem_w < i_geom.dwd) ? rem_w : i_geom.dwd;
        se_raw = (2*K_W)'(sub_w) * (2*K_W)'(sub_h);
        se_r1  = SE_W'(se_raw) + SE_W'(1);
        se_r3  = SE_W'(se_raw) + SE_W'(3);
        if (i_geom.pk) begin
            se = i_geom.b16 ? {se_r1[SE_W-1:1], 1'b0} : {se_r3[SE_W-1:2], 2'b00};
        end else if (i_geom.dw) begin
            se = {se_r3[SE_W-1:2], 2'b00};
        end else begin
            se = SE_W'(se_raw);
        end

        rem_o    = i_geom.ofm_d - r_obb;
        out_blk_lim = (32'(i_geom.obd) < 32'(rem_o)) ? i_geom.obd : 8'(rem_o);
        rem_i    = i_geom.ifm_d - r_ibb;
        if (i_geom.dw) begin
            in_blk_lim = CI_W'(IN_UBLOCK);
        end else if (i_geom.pk) begin
            in_blk_lim = (32'(i_geom.ibd) < 32'(rem_i)) ? i_geom.ibd : CI_W'(rem_i);
        end else begin
            in_blk_lim = i_geom.ibd;
        end
        outer_lim = i_geom.pk ? in_blk_lim : CI_W'(1);
        inner_lim = i_geom.pk ? CI_W'(1) : in_blk_lim;
        im_bound  = i_geom.dw ? IM_W'(1) : IM_W'(IN_UBLOCK);

        s_im  = {1'b0, r_im} + (IM_W+1)'(1);
        s_om  = {1'b0, r_om} + (OM_W+1)'(1);
        s_iin = r_iin + IB_W'(IN_UBLOCK);
        s_el  = r_el + SE_W'(1);
        s_kx  = r_kx + (K_W+1)'(1);
        s_ouo = r_ouo + OU_W'(OUT_UBLOCK);
        s_ioo = r_ioo + IB_W'(IN_UBLOCK);
        s_skc = {1'b0, r_skc} + {1'b0, i_geom.dwd};
        s_skr = {1'b0, r_skr} + {1'b0, i_geom.dh};
        s_ibb = (CH_W+8)'(r_ibb) + (CH_W+8)'(i_geom.ibd);
        s_obb = (CH_W+8)'(r_obb) + (CH_W+8)'(i_geom.obd);

        w_im  = s_im >= (IM_W+1)'(im_bound);
        w_om  = s_om >= (OM_W+1)'(OUT_UBLOCK);
        w_iin = s_iin >= IB_W'(inner_lim);
        w_el  = s_el >= se;
        w_ouo = s_ouo >= OU_W'(out_blk_lim);
        w_ioo = s_ioo >= IB_W'(outer_lim);
        w_skc = s_skc >= (K_W+1)'(i_geom.kw);
        w_skr = s_skr >= (K_W+1)'(i_geom.kh);
        w_ibb = s_ibb >= (CH_W+8)'(i_geom.in_bound);
        w_obb = s_obb >= (CH_W+8)'(i_geom.ofm_d);

        e1   = active && w_im;
        e2   = e1 && w_om;
        e3   = e2 && w_iin;
        e4   = e3 && w_el;
        e5   = e4 && w_ouo;
        e6   = e5 && w_ioo;
        e7   = e6 && w_skc;
        e8   = e7 && w_skr;
        e9   = e8 && w_ibb;
        done = e9 && w_obb;

        iz = (CH_W+1)'(r_ibb) + (CH_W+1)'(r_iin) + (CH_W+1)'(r_ioo) + (CH_W+1)'(r_im);
        oz = (CH_W+1)'(r_obb) + (CH_W+1)'(r_ouo) + (CH_W+1)'(r_om);

        n_im  = r_im;
        n_om  = r_om;
        n_iin = r_iin;
        n_el  = r_el;
        n_kx  = r_kx;
        n_ky  = r_ky;
        n_ouo = r_ouo;
        n_ioo = r_ioo;
        n_skc = r_skc;
        n_skr = r_skr;
        n_ibb = r_ibb;
        n_obb = r_obb;
        n_finished = r_finished || done;

        if (active) begin
            n_im = w_im ? '0 : s_im[IM_W-1:0];
        end
        if (e1) begin
            n_om = w_om ? '0 : s_om[OM_W-1:0];
        end
        if (e2) begin
            n_iin = w_iin ? '0 : s_iin;
        end
        if (e3) begin
            n_el = w_el ? '0 : s_el;
            if (w_el) begin
                n_kx = '0;
                n_ky = '0;
            end else if (s_kx >= (K_W+1)'(sub_w)) begin
                n_kx = '0;
                n_ky = r_ky + (K_W+1)'(1);
            end else begin
                n_kx = s_kx;
            end
        end
        if (e4) begin
            n_ouo = w_ouo ? '0 : s_ouo;
        end
        if (e5) begin
            n_ioo = w_ioo ? '0 : s_ioo;
        end
        if (e6) begin
            n_skc = w_skc ? '0 : s_skc[K_W-1:0];
        end
        if (e7) begin
            n_skr = w_skr ? '0 : s_skr[K_W-1:0];
        end
        if (e8) begin
            n_ibb = w_ibb ? '0 : s_ibb[CH_W-1:0];
        end
        if (e9) begin
            n_obb = w_obb ? '0 : s_obb[CH_W-1:0];
        end

        o_entry.we_ok = active && (iz < (CH_W+1)'(i_geom.ifm_d))
            && (oz < (CH_W+1)'(i_geom.ofm_d)) && (r_ky < (K_W+1)'(sub_h));
        o_entry.oz           = oz;
        o_entry.iz           = iz;
        o_entry.y            = (K_W+1)'(r_skr) + r_ky;
        o_entry.x            = (K_W+1)'(r_skc) + r_kx;
        o_entry.weight       = i_in.weight;
        o_entry.done_res     = done;
        o_entry.short_stream = i_in.last && !n_finished && !i_geom.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (accept && i_in.last)) begin
            r_im       <= '0;
            r_om       <= '0;
            r_iin      <= '0;
            r_el       <= '0;
            r_kx       <= '0;
            r_ky       <= '0;
            r_ouo      <= '0;
            r_ioo      <= '0;
            r_skc      <= '0;
            r_skr      <= '0;
            r_ibb      <= '0;
            r_obb      <= '0;
            r_finished <= 1'b0;
        end else if (accept) begin
            r_im       <= n_im;
            r_om       <= n_om;
            r_iin      <= n_iin;
            r_el       <= n_el;
            r_kx       <= n_kx;
            r_ky       <= n_ky;
            r_ouo      <= n_ouo;
            r_ioo      <= n_ioo;
            r_skc      <= n_skc;
            r_skr      <= n_skr;
            r_ibb      <= n_ibb;
            r_obb      <= n_obb;
            r_finished <= n_finished;
        end
    end

endmodule

@@ rtl/wsir_back.sv @@
// ---------------------------------------------------------------------------
// wsir_back
// address unit: ohwi index in three multiply-add steps, output register
// ---------------------------------------------------------------------------
module wsir_back
    import wsir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_geom       i_geom,
    input  t_entry      i_entry,
    input  logic        i_empty,
    output logic        o_pop,
    wsir_res_if.source  o_res
);

    t_back_state           r_state, n_state;
    t_entry                r_ent;
    logic [A3_W-1:0]       r_acc, n_acc;
    logic                  r_out_valid;
    logic                  r_out_we;
    logic [ADDR_WIDTH-1:0] r_out_addr;
    logic signed [15:0]    r_out_value;
    logic                  r_out_done;
    logic                  r_out_short;
    logic                  load;
    logic [A1_W-1:0]       a1;
    logic [A2_W-1:0]       a2;
    logic [A3_W-1:0]       a3;
    logic                  fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        o_pop   = 1'b0;
        load    = 1'b0;
        a1 = A1_W'(r_ent.oz) * A1_W'(i_geom.kh) + A1_W'(r_ent.y);
        a2 = A2_W'(r_acc[A1_W-1:0]) * A2_W'(i_geom.kw) + A2_W'(r_ent.x);
        a3 = A3_W'(r_acc[A2_W-1:0]) * A3_W'(i_geom.ifm_d) + A3_W'(r_ent.iz);
        fits = (a3 >> ADDR_WIDTH) == '0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_ROW;
                end
            end
            BK_ROW: begin
                n_acc   = A3_W'(a1);
                n_state = BK_COL;
            end
            BK_COL: begin
                n_acc   = A3_W'(a2);
                n_state = BK_CHAN;
            end
            BK_CHAN: begin
                if (!r_out_valid || o_res.ready) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        r_acc <= n_acc;
        if (load) begin
            r_out_we    <= r_ent.we_ok && fits;
            r_out_addr  <= (r_ent.we_ok && fits) ? a3[ADDR_WIDTH-1:0] : '0;
            r_out_value <= r_ent.weight;
            r_out_done  <= r_ent.done_res;
            r_out_short <= r_ent.short_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.write_enable = r_out_we;
    assign o_res.address      = r_out_addr;
    assign o_res.value        = r_out_value;
    assign o_res.done_res     = r_out_done;
    assign o_res.short_stream = r_out_short;

endmodule

@@ rtl/weight_stream_inverse_reorder_top.sv @@
// each input transaction is queued, fetched by the address unit, taken through its
// three multiply-add steps and loaded into the output register once that is free;
// the address unit fetches the next one only after that load, so its fetch and steps
// set the throughput; the front takes one per cycle until the 4-entry queue fills
// reset: synchronous; registers to defaults, traversal counters cleared, queue empty
// ---------------------------------------------------------------------------
// weight_stream_inverse_reorder_top
// configuration registers, traversal front, queue and address back end
// ---------------------------------------------------------------------------
module weight_stream_inverse_reorder_top
    import wsir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    wsir_in_if.sink            i_in,
    wsir_res_if.source         o_res
);

    logic [OC_REG_W-1:0]  r_oc, r_ic;
    logic [KS_REG_W-1:0]  r_kh, r_kw, r_dh, r_dwd;
    logic [OBD_REG_W-1:0] r_obd;
    logic [MD_REG_W-1:0]  r_mode;
    logic                 cfg_wr;
    t_reg_idx             reg_idx;
    t_geom                geom;
    logic                 push, full, pop, empty;
    t_entry               push_entry, pop_entry;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc   <= OC_REG_W'(1);
            r_ic   <= OC_REG_W'(1);
            r_kh   <= KS_REG_W'(1);
            r_kw   <= KS_REG_W'(1);
            r_obd  <= OBD_REG_W'(8);
            r_dh   <= KS_REG_W'(1);
            r_dwd  <= KS_REG_W'(1);
            r_mode <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_OUT_CHANNELS:    r_oc   <= pwdata[OC_REG_W-1:0];
                REG_IN_CHANNELS:     r_ic   <= pwdata[OC_REG_W-1:0];
                REG_KERNEL_HEIGHT:   r_kh   <= pwdata[KS_REG_W-1:0];
                REG_KERNEL_WIDTH:    r_kw   <= pwdata[KS_REG_W-1:0];
                REG_OUT_BLOCK_DEPTH: r_obd  <= pwdata[OBD_REG_W-1:0];
                REG_DECOMP_HEIGHT:   r_dh   <= pwdata[KS_REG_W-1:0];
                REG_DECOMP_WIDTH:    r_dwd  <= pwdata[KS_REG_W-1:0];
                REG_MODE:            r_mode <= pwdata[MD_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OUT_CHANNELS:    prdata = PDATA_W'(r_oc);
            REG_IN_CHANNELS:     prdata = PDATA_W'(r_ic);
            REG_KERNEL_HEIGHT:   prdata = PDATA_W'(r_kh);
            REG_KERNEL_WIDTH:    prdata = PDATA_W'(r_kw);
            REG_OUT_BLOCK_DEPTH: prdata = PDATA_W'(r_obd);
            REG_DECOMP_HEIGHT:   prdata = PDATA_W'(r_dh);
            REG_DECOMP_WIDTH:    prdata = PDATA_W'(r_dwd);
            REG_MODE:            prdata = PDATA_W'(r_mode);
            default:             prdata = '0;
        endcase
    end

    // sanitised geometry
    always_comb begin
        geom.ofm_d    = sat_ch(r_oc);
        geom.ifm_d    = sat_ch(r_ic);
        geom.kh       = sat_k(r_kh);
        geom.kw       = sat_k(r_kw);
        geom.dh       = sat_k((r_dh == '0) ? KS_REG_W'(1) : r_dh);
        geom.dwd      = sat_k((r_dwd == '0) ? KS_REG_W'(1) : r_dwd);
        geom.obd      = (r_obd == '0) ? OBD_REG_W'(1) : r_obd;
        geom.dw       = r_mode[0];
        geom.pk       = r_mode[1];
        geom.b16      = r_mode[2];
        geom.ibd      = (r_mode[1] || r_mode[2]) ? CI_W'(16) : CI_W'(32);
        geom.in_bound = r_mode[0] ? CH_W'(1) : geom.ifm_d;
        geom.empty    = (geom.ofm_d == '0) || (geom.kh == '0) || (geom.kw == '0)
            || (geom.in_bound == '0);
    end

    wsir_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (cfg_wr),
        .i_in      (i_in),
        .o_push    (push),
        .o_entry   (push_entry),
        .i_full    (full)
    );

    wsir_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    wsir_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_entry (pop_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
